### hdl/crc8_frame_builder_assert.svh
`ifndef CRC8_FRAME_BUILDER_ASSERT_SVH
`define CRC8_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CRCFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CRCFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/crcfb_pkg.sv
package crcfb_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;
	localparam logic [7:0] FTR_FIRST  = 8'hCC;
	localparam logic [7:0] FTR_SECOND = 8'h33;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] CRC_INIT   = 8'h00;

	// one accepted payload byte with everything the emitter needs
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] crc;
		logic       first;
		logic       last;
	} job_t;

	typedef enum logic [5:0] {
		PH_HDR1 = 6'b000001,
		PH_HDR2 = 6'b000010,
		PH_DATA = 6'b000100,
		PH_CRC  = 6'b001000,
		PH_FTR1 = 6'b010000,
		PH_FTR2 = 6'b100000
	} phase_t;

	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### hdl/crcfb_track.sv
module crcfb_track #(
	parameter int PAYLOAD_BYTES = 44
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        payload_byte,
	output crcfb_pkg::job_t   job
);

	localparam logic [8:0] LAST_LIMIT = 9'(PAYLOAD_BYTES);

	logic [7:0] pos_q;
	logic [7:0] crc_q;
	logic [7:0] crc_next;
	logic       last;

	assign crc_next = crcfb_pkg::crc8_fold(crc_q, payload_byte);
	assign last     = ({1'b0, pos_q} + 9'd1) >= LAST_LIMIT;

	assign job.data  = payload_byte;
	assign job.crc   = crc_next;
	assign job.first = (pos_q == 8'd0);
	assign job.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 8'd0;
			crc_q <= crcfb_pkg::CRC_INIT;
		end else if (accept) begin
			if (last) begin
				pos_q <= 8'd0;
				crc_q <= crcfb_pkg::CRC_INIT;
			end else begin
				pos_q <= pos_q + 8'd1;
				crc_q <= crc_next;
			end
		end
	end

endmodule

### hdl/crcfb_emit.sv
module crcfb_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  crcfb_pkg::job_t job,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            frame_end
);

	crcfb_pkg::job_t   job_s1;
	logic              job_valid_s1;
	crcfb_pkg::phase_t phase_q;
	crcfb_pkg::phase_t phase_next;
	logic [7:0]        slot_byte;
	logic              load;
	logic              slot_final;
	logic              job_done;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              run_last_q;
	logic              frame_end_q;

	assign load       = job_valid_s1 && (!out_valid_q || out_ready);
	assign slot_final = ((phase_q == crcfb_pkg::PH_DATA) && !job_s1.last) ||
		(phase_q == crcfb_pkg::PH_FTR2);
	assign job_done   = load && slot_final;
	assign job_ready  = !job_valid_s1 || job_done;

	always_comb begin
		case (phase_q)
			crcfb_pkg::PH_HDR1: begin
				slot_byte  = crcfb_pkg::HDR_FIRST;
				phase_next = crcfb_pkg::PH_HDR2;
			end
			crcfb_pkg::PH_HDR2: begin
				slot_byte  = crcfb_pkg::HDR_SECOND;
				phase_next = crcfb_pkg::PH_DATA;
			end
			crcfb_pkg::PH_DATA: begin
				slot_byte  = job_s1.data;
				phase_next = crcfb_pkg::PH_CRC;
			end
			crcfb_pkg::PH_CRC: begin
				slot_byte  = job_s1.crc;
				phase_next = crcfb_pkg::PH_FTR1;
			end
			crcfb_pkg::PH_FTR1: begin
				slot_byte  = crcfb_pkg::FTR_FIRST;
				phase_next = crcfb_pkg::PH_FTR2;
			end
			crcfb_pkg::PH_FTR2: begin
				slot_byte  = crcfb_pkg::FTR_SECOND;
				phase_next = crcfb_pkg::PH_HDR1;
			end
			default: begin
				slot_byte  = crcfb_pkg::HDR_FIRST;
				phase_next = crcfb_pkg::PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			phase_q      <= crcfb_pkg::PH_HDR1;
		end else if (job_valid && job_ready) begin
			job_valid_s1 <= 1'b1;
			phase_q      <= job.first ? crcfb_pkg::PH_HDR1 : crcfb_pkg::PH_DATA;
		end else if (job_done) begin
			job_valid_s1 <= 1'b0;
		end else if (load) begin
			phase_q <= phase_next;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_s1 <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= slot_byte;
			run_last_q  <= slot_final;
			frame_end_q <= (phase_q == crcfb_pkg::PH_FTR2);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

endmodule

### hdl/crc8_frame_builder.sv
// channel | signals                          | direction
// in      | in_valid, in_ready, payload_byte | sink
// out     | out_valid, out_ready, out_byte,  | source
//         | run_last, frame_end              |
//
// a middle byte is sent alone; with out_ready high bytes stream at one per cycle
// the first byte of a frame follows the two header bytes, and the last is followed
// by the crc and two footer bytes, one frame byte per cycle while out_ready is high
// input byte is held in a one-entry job register while the emitter walks its slots
// arst_n clears the frame position, crc and all valid flags
// out_ready low stalls the emitter and, once the job register is busy, the input
`include "crc8_frame_builder_assert.svh"

module crc8_frame_builder #(
	parameter int PAYLOAD_BYTES = 44
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] payload_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end
);

	crcfb_pkg::job_t job;
	logic            accept;

	assign accept = in_valid && in_ready;

	crcfb_track #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.payload_byte(payload_byte),
		.job         (job)
	);

	crcfb_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(in_valid),
		.job_ready(in_ready),
		.job      (job),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.run_last (run_last),
		.frame_end(frame_end)
	);

	`CRCFB_ASSERT_NOW(a_end_is_last, out_valid && frame_end, run_last, "frame end without run last")
	`CRCFB_ASSERT_NEXT(a_run_no_gap, out_valid && out_ready && !run_last, out_valid, "gap inside run")
	`CRCFB_ASSERT_NEXT(a_hdr_after_end, out_valid && out_ready && frame_end,
		!out_valid || (out_byte == crcfb_pkg::HDR_FIRST), "new frame without header")

endmodule
